### hw/rtl/cct_pkg.sv
// Shared types, constants and helpers for the category color table.
package cct_pkg;

    localparam int DEPTH      = 4096;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int CAT_W      = 32;
    localparam int DIFF_W     = CAT_W + 1;
    localparam int LEVEL_IN_W = 16;
    localparam int COLOR_W    = 8;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 96;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CAPACITY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;

    localparam logic [COLOR_W-1:0] WHITE = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_FILL,
        S_WRITE,
        S_RDATA,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                     is_set;
        logic [COLOR_W-1:0]       blue;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       red;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                     op;
        logic signed [CAT_W-1:0]  category;
        logic [COLOR_W-1:0]       red;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       blue;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [COLOR_W-1:0]       red;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       blue;
        logic                     is_set;
        logic signed [CAT_W-1:0]  span_low;
        logic signed [CAT_W-1:0]  span_high;
    } res_t;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        entry_t                   wdata;
        logic                     re;
        logic [ADDR_W-1:0]        raddr;
    } ram_req_t;

    typedef struct packed {
        logic                     idle;
        logic                     res_valid;
    } ctrl_stat_t;

    function automatic logic [COLOR_W-1:0] clamp_level(input logic signed [LEVEL_IN_W-1:0] x);
        logic [COLOR_W-1:0] y;
        if (x[LEVEL_IN_W-1])
            y = '0;
        else if (x[LEVEL_IN_W-2:COLOR_W] != '0)
            y = WHITE;
        else
            y = x[COLOR_W-1:0];
        return y;
    endfunction

endpackage

### hw/rtl/cct_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module cct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cct_ctrl.sv
// Sequencer and span bookkeeping: range checks, gap fill walk, RAM access.
module cct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cct_pkg::req_t       req,
    input  logic                out_free,
    input  cct_pkg::entry_t     rdata,
    output cct_pkg::ram_req_t   ram,
    output cct_pkg::ctrl_stat_t stat,
    output cct_pkg::res_t       res
);

    cct_pkg::state_t state_reg, state_next;

    logic                                  active_reg, active_next;
    logic signed [cct_pkg::CAT_W-1:0]      low_reg, low_next;
    logic signed [cct_pkg::CAT_W-1:0]      high_reg, high_next;
    logic [cct_pkg::ADDR_W-1:0]            base_reg, base_next;
    logic [cct_pkg::LEN_W-1:0]             len_reg, len_next;

    cct_pkg::req_t                         req_reg, req_next;
    logic signed [cct_pkg::DIFF_W-1:0]     hi_diff_reg, hi_diff_next;
    logic signed [cct_pkg::DIFF_W-1:0]     lo_diff_reg, lo_diff_next;
    logic signed [cct_pkg::DIFF_W-1:0]     off_reg, off_next;
    logic [cct_pkg::ADDR_W-1:0]            fill_addr_reg, fill_addr_next;
    logic [cct_pkg::ADDR_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic [cct_pkg::ADDR_W-1:0]            wr_addr_reg, wr_addr_next;
    logic [cct_pkg::STATUS_W-1:0]          status_reg, status_next;
    cct_pkg::entry_t                       color_reg, color_next;

    // decision terms, valid in S_DECIDE
    logic                                  is_ins, above, below, cap_err, hit;
    logic [cct_pkg::ADDR_W-1:0]            gap_lo;
    logic [cct_pkg::ADDR_W-1:0]            new_base;
    logic [cct_pkg::LEN_W-1:0]             len_below;
    logic [cct_pkg::ADDR_W-1:0]            fill_cnt_calc;
    logic [cct_pkg::ADDR_W-1:0]            fill_addr_calc;
    logic [cct_pkg::ADDR_W-1:0]            wr_addr_calc;
    logic [cct_pkg::LEN_W-1:0]             len_calc;

    always_comb
    begin
        is_ins    = (req_reg.op == cct_pkg::OP_INSERT);
        above     = (hi_diff_reg > 0);
        below     = (lo_diff_reg > 0);
        gap_lo    = lo_diff_reg[cct_pkg::ADDR_W-1:0];
        new_base  = base_reg - gap_lo;
        len_below = len_reg + {1'b0, gap_lo};
        hit       = active_reg && !above && !below;
        cap_err   = 1'b0;
        fill_cnt_calc  = '0;
        fill_addr_calc = base_reg + len_reg[cct_pkg::ADDR_W-1:0];
        wr_addr_calc   = base_reg + off_reg[cct_pkg::ADDR_W-1:0];
        len_calc       = len_reg;
        if (!active_reg)
        begin
            wr_addr_calc = '0;
            len_calc     = cct_pkg::LEN_W'(1);
        end
        else if (above)
        begin
            cap_err       = (off_reg[cct_pkg::DIFF_W-1:cct_pkg::ADDR_W] != '0);
            fill_cnt_calc = hi_diff_reg[cct_pkg::ADDR_W-1:0] - cct_pkg::ADDR_W'(1);
            len_calc      = {1'b0, off_reg[cct_pkg::ADDR_W-1:0]} + cct_pkg::LEN_W'(1);
        end
        else if (below)
        begin
            cap_err        = (lo_diff_reg[cct_pkg::DIFF_W-1:cct_pkg::ADDR_W] != '0)
                          || (len_below > cct_pkg::LEN_W'(cct_pkg::DEPTH));
            fill_cnt_calc  = gap_lo - cct_pkg::ADDR_W'(1);
            fill_addr_calc = new_base + cct_pkg::ADDR_W'(1);
            wr_addr_calc   = new_base;
            len_calc       = len_below;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cct_pkg::S_IDLE:
                if (start)
                    state_next = cct_pkg::S_CALC;
            cct_pkg::S_CALC:
                state_next = cct_pkg::S_DECIDE;
            cct_pkg::S_DECIDE:
                if (!is_ins)
                    state_next = hit ? cct_pkg::S_RDATA : cct_pkg::S_OUT;
                else if (cap_err || fill_cnt_calc == '0)
                    state_next = cct_pkg::S_OUT;
                else
                    state_next = cct_pkg::S_FILL;
            cct_pkg::S_FILL:
                if (fill_cnt_reg == cct_pkg::ADDR_W'(1))
                    state_next = cct_pkg::S_WRITE;
            cct_pkg::S_WRITE:
                state_next = cct_pkg::S_OUT;
            cct_pkg::S_RDATA:
                state_next = cct_pkg::S_OUT;
            cct_pkg::S_OUT:
                if (out_free)
                    state_next = cct_pkg::S_IDLE;
            default:
                state_next = cct_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        req_next       = req_reg;
        hi_diff_next   = hi_diff_reg;
        lo_diff_next   = lo_diff_reg;
        off_next       = off_reg;
        fill_addr_next = fill_addr_reg;
        fill_cnt_next  = fill_cnt_reg;
        wr_addr_next   = wr_addr_reg;
        status_next    = status_reg;
        color_next     = color_reg;
        ram            = '0;
        stat.idle      = (state_reg == cct_pkg::S_IDLE);
        stat.res_valid = 1'b0;

        case (state_reg)
            cct_pkg::S_IDLE:
                if (start)
                    req_next = req;
            cct_pkg::S_CALC:
            begin
                hi_diff_next = {req_reg.category[cct_pkg::CAT_W-1], req_reg.category}
                             - {high_reg[cct_pkg::CAT_W-1], high_reg};
                lo_diff_next = {low_reg[cct_pkg::CAT_W-1], low_reg}
                             - {req_reg.category[cct_pkg::CAT_W-1], req_reg.category};
                off_next     = {req_reg.category[cct_pkg::CAT_W-1], req_reg.category}
                             - {low_reg[cct_pkg::CAT_W-1], low_reg};
            end
            cct_pkg::S_DECIDE:
            begin
                color_next  = '{is_set: 1'b0, blue: cct_pkg::WHITE, green: cct_pkg::WHITE,
                                red: cct_pkg::WHITE};
                status_next = cct_pkg::ST_DONE;
                if (!is_ins)
                begin
                    ram.re    = hit;
                    ram.raddr = base_reg + off_reg[cct_pkg::ADDR_W-1:0];
                    if (!hit)
                        status_next = cct_pkg::ST_MISS;
                end
                else if (cap_err)
                    status_next = cct_pkg::ST_CAPACITY;
                else
                begin
                    active_next = 1'b1;
                    len_next    = len_calc;
                    if (!active_reg)
                    begin
                        low_next  = req_reg.category;
                        high_next = req_reg.category;
                        base_next = '0;
                    end
                    else if (above)
                        high_next = req_reg.category;
                    else if (below)
                    begin
                        low_next  = req_reg.category;
                        base_next = new_base;
                    end
                    fill_cnt_next  = fill_cnt_calc;
                    fill_addr_next = fill_addr_calc;
                    wr_addr_next   = wr_addr_calc;
                    color_next     = '{is_set: 1'b1, blue: req_reg.blue,
                                       green: req_reg.green, red: req_reg.red};
                    if (fill_cnt_calc == '0)
                    begin
                        ram.we    = 1'b1;
                        ram.waddr = wr_addr_calc;
                        ram.wdata = '{is_set: 1'b1, blue: req_reg.blue,
                                      green: req_reg.green, red: req_reg.red};
                    end
                end
            end
            cct_pkg::S_FILL:
            begin
                ram.we         = 1'b1;
                ram.waddr      = fill_addr_reg;
                ram.wdata      = '{is_set: 1'b0, blue: cct_pkg::WHITE,
                                   green: cct_pkg::WHITE, red: cct_pkg::WHITE};
                fill_addr_next = fill_addr_reg + cct_pkg::ADDR_W'(1);
                fill_cnt_next  = fill_cnt_reg - cct_pkg::ADDR_W'(1);
            end
            cct_pkg::S_WRITE:
            begin
                ram.we    = 1'b1;
                ram.waddr = wr_addr_reg;
                ram.wdata = color_reg;
            end
            cct_pkg::S_RDATA:
                color_next = rdata;
            cct_pkg::S_OUT:
                stat.res_valid = 1'b1;
            default:
                ram = '0;
        endcase

        res.status    = status_reg;
        res.red       = color_reg.red;
        res.green     = color_reg.green;
        res.blue      = color_reg.blue;
        res.is_set    = color_reg.is_set;
        res.span_low  = low_reg;
        res.span_high = high_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cct_pkg::S_IDLE;
            active_reg <= 1'b0;
            low_reg    <= '0;
            high_reg   <= '0;
            base_reg   <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            base_reg   <= base_next;
            len_reg    <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hi_diff_reg   <= hi_diff_next;
        lo_diff_reg   <= lo_diff_next;
        off_reg       <= off_next;
        fill_addr_reg <= fill_addr_next;
        fill_cnt_reg  <= fill_cnt_next;
        wr_addr_reg   <= wr_addr_next;
        status_reg    <= status_next;
        color_reg     <= color_next;
    end

endmodule

### hw/rtl/category_color_table.sv
// Top level of the category color table: stream ports, result register, core.
//
//  channel | dir | handshake         | contents
//  s_axis  | in  | s_tvalid/s_tready | tuser: operation; tdata: category, red, green, blue
//  m_axis  | out | m_tvalid/m_tready | tuser: status; tdata: colors, is_set, span
//
// Per accepted beat the core passes S_CALC and S_DECIDE, where an insert with
// no gap writes its entry; else S_FILL writes each gap entry white, then S_WRITE
// the entry. A read hit passes S_RDATA for the registered RAM read. All end in
// S_OUT. The RAM has one write port, so a gap fill walks one entry per cycle.
// Reset clears the span and the table-active flag; RAM contents need no clear.
// The result register frees the core at once, so a stalled m_tready only holds
// the core once a second result is ready.
module category_color_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [0:0]                      s_tuser,  // [0] operation
    // [31:0] category, [47:32] red_in, [63:48] green_in, [79:64] blue_in
    input  logic [cct_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cct_pkg::STATUS_W-1:0]    m_tuser,  // [1:0] status
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [24] is_set,
    // [56:25] span_low, [88:57] span_high, [95:89] zero
    output logic [cct_pkg::M_TDATA_W-1:0]   m_tdata
);

    cct_pkg::req_t       req;
    cct_pkg::res_t       res;
    cct_pkg::ram_req_t   ram;
    cct_pkg::entry_t     rdata;
    cct_pkg::ctrl_stat_t stat;
    logic [cct_pkg::ENTRY_W-1:0] rdata_raw;

    logic          m_tvalid_reg;
    cct_pkg::res_t out_reg;
    logic          out_free;
    logic          start;

    assign req.op       = s_tuser[0];
    assign req.category = s_tdata[31:0];
    assign req.red      = cct_pkg::clamp_level(s_tdata[47:32]);
    assign req.green    = cct_pkg::clamp_level(s_tdata[63:48]);
    assign req.blue     = cct_pkg::clamp_level(s_tdata[79:64]);

    assign s_tready = stat.idle;
    assign start    = s_tvalid && stat.idle;
    assign out_free = !m_tvalid_reg || m_tready;

    cct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .rdata    (rdata),
        .ram      (ram),
        .stat     (stat),
        .res      (res)
    );

    cct_ram #(
        .WIDTH (cct_pkg::ENTRY_W),
        .DEPTH (cct_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata_raw)
    );

    assign rdata = rdata_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (stat.res_valid && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && out_free)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.span_high, out_reg.span_low, out_reg.is_set,
                       out_reg.blue, out_reg.green, out_reg.red};

endmodule

### hw/rtl/cct_checker.sv
// Port-level checks for the category color table, bound to the top level.
module cct_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [0:0]                      s_tuser,
    input logic [cct_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cct_pkg::STATUS_W-1:0]    m_tuser,
    input logic [cct_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic in_beat;
    assign in_beat = s_tvalid && s_tready && (s_tuser[0] == cct_pkg::OP_INSERT || s_tdata != '0);

    // an error or miss answers white and unset
    a_err_white: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cct_pkg::ST_DONE |-> m_tdata[24:0] == 25'h0FFFFFF)
        else $error("error result not white/unset");

    // span never inverted
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[56:25]) <= $signed(m_tdata[88:57]))
        else $error("span_low above span_high");

    // a set mark only comes with a done status
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24] |-> m_tuser == cct_pkg::ST_DONE)
        else $error("set mark on failed operation");

    // core takes no new beat in the cycle right after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input accepted while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind category_color_table cct_checker u_cct_checker (.*);
